FILE: rtl/core/cle_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Console line editor package
// Shared widths, character codes, class and source codes, and the
// command / status words passed between controller and datapath.
// ----------------------------------------------------------------------------
package cle_pkg;

    localparam int DataW    = 8;
    localparam int KindW    = 2;
    localparam int LenW     = 4;
    localparam int CharW    = 7;
    localparam int LimitW   = 4;
    localparam int ApbAddrW = 3;
    localparam int ApbDataW = 32;

    typedef logic [KindW-1:0] t_kind;
    localparam t_kind KIND_ECHO = 2'd0;
    localparam t_kind KIND_BELL = 2'd1;
    localparam t_kind KIND_BYTE = 2'd2;
    localparam t_kind KIND_DONE = 2'd3;

    // register map (word index taken from paddr[2])
    localparam logic REG_LINE_LIMIT = 1'b0;
    localparam logic [LimitW-1:0] LIMIT_RESET = 4'd15;

    // character codes
    localparam logic [DataW-1:0] CH_ETX   = 8'd3;    // ctrl-C
    localparam logic [DataW-1:0] CH_BS    = 8'd8;
    localparam logic [DataW-1:0] CH_LF    = 8'd10;
    localparam logic [DataW-1:0] CH_CR    = 8'd13;
    localparam logic [DataW-1:0] CH_DC2   = 8'd18;   // ctrl-R
    localparam logic [DataW-1:0] CH_NAK   = 8'd21;   // ctrl-U
    localparam logic [DataW-1:0] CH_ETB   = 8'd23;   // ctrl-W
    localparam logic [DataW-1:0] CH_SP    = 8'd32;
    localparam logic [DataW-1:0] CH_UC_C  = 8'd67;
    localparam logic [DataW-1:0] CH_UC_R  = 8'd82;
    localparam logic [DataW-1:0] CH_CARET = 8'd94;
    localparam logic [DataW-1:0] CH_DEL   = 8'd127;

    // classes of a typed word
    typedef logic [2:0] t_class;
    localparam t_class CL_ENTER   = 3'd0;
    localparam t_class CL_PRINT   = 3'd1;
    localparam t_class CL_BKSP    = 3'd2;
    localparam t_class CL_INTR    = 3'd3;
    localparam t_class CL_REPRINT = 3'd4;
    localparam t_class CL_KILL    = 3'd5;
    localparam t_class CL_WERASE  = 3'd6;
    localparam t_class CL_OTHER   = 3'd7;

    // result sources
    typedef logic [2:0] t_src;
    localparam t_src SRC_NONE   = 3'd0;
    localparam t_src SRC_CHAR   = 3'd1;
    localparam t_src SRC_BELL   = 3'd2;
    localparam t_src SRC_PREFIX = 3'd3;
    localparam t_src SRC_LIST   = 3'd4;
    localparam t_src SRC_DONE   = 3'd5;
    localparam t_src SRC_ERASE  = 3'd6;

    typedef struct packed {
        logic load;
        logic emit;
        t_src src;
        logic last;
    } t_cmd;

    typedef struct packed {
        t_class cls;
        logic   fill_zero;
        logic   room;
        logic   out_free;
        logic   step_end;
        logic   idx_end;
        logic   erase_more;
    } t_stat;

endpackage
`default_nettype wire

FILE: rtl/core/cle_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Console line editor channels
// Valid/ready channels for typed words and for result words.
// ----------------------------------------------------------------------------
interface cle_in_if;
    logic                      valid;
    logic                      ready;
    logic [cle_pkg::DataW-1:0] typed_byte;

    modport source (output valid, output typed_byte, input ready);
    modport sink   (input valid, input typed_byte, output ready);
endinterface

interface cle_out_if;
    logic                      valid;
    logic                      ready;
    logic [cle_pkg::KindW-1:0] kind;
    logic [cle_pkg::DataW-1:0] out_byte;
    logic [cle_pkg::LenW-1:0]  line_length;
    logic                      last;

    modport source (output valid, output kind, output out_byte, output line_length,
                    output last, input ready);
    modport sink   (input valid, input kind, input out_byte, input line_length,
                    input last, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/cle_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Console line editor datapath
// Line store, fill count, loop counters and the result output register.
// ----------------------------------------------------------------------------
module cle_datapath #(
    parameter int LINE_DEPTH = 16
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire  cle_pkg::t_cmd          i_cmd,
    output cle_pkg::t_stat               o_stat,
    input  wire  [cle_pkg::DataW-1:0]    i_typed_byte,
    input  wire  [cle_pkg::LimitW-1:0]   i_line_limit,
    output logic                         o_out_valid,
    input  wire                          i_out_ready,
    output logic [cle_pkg::KindW-1:0]    o_out_kind,
    output logic [cle_pkg::DataW-1:0]    o_out_byte,
    output logic [cle_pkg::LenW-1:0]     o_out_len,
    output logic                         o_out_last
);
    import cle_pkg::*;

    localparam int IdxW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam logic [LenW-1:0] MaxFill = LenW'(LINE_DEPTH - 1);

    logic [CharW-1:0] r_store [LINE_DEPTH];
    logic [DataW-1:0] r_char;
    logic [LenW-1:0]  r_fill, n_fill;
    logic [LenW-1:0]  r_idx;
    logic [1:0]       r_step;
    logic             r_word;
    logic             r_out_valid;
    t_kind            r_out_kind;
    logic [DataW-1:0] r_out_byte;
    logic [LenW-1:0]  r_out_len;
    logic             r_out_last;

    t_class           cls;
    logic [LenW-1:0]  eff_limit;
    logic [LenW-1:0]  fill_m1, fill_m2, rd_sel;
    logic [IdxW-1:0]  rd_idx, wr_idx;
    logic [CharW-1:0] rd_char;
    logic             out_free, step_end;
    t_kind            res_kind;
    logic [DataW-1:0] res_byte;
    logic [LenW-1:0]  res_len;

    // classify the held word
    always_comb begin
        if (r_char == CH_LF || r_char == CH_CR) begin
            cls = CL_ENTER;
        end else if (r_char >= CH_SP && r_char < CH_DEL) begin
            cls = CL_PRINT;
        end else if (r_char == CH_BS || r_char == CH_DEL) begin
            cls = CL_BKSP;
        end else if (r_char == CH_ETX) begin
            cls = CL_INTR;
        end else if (r_char == CH_DC2) begin
            cls = CL_REPRINT;
        end else if (r_char == CH_NAK) begin
            cls = CL_KILL;
        end else if (r_char == CH_ETB) begin
            cls = CL_WERASE;
        end else begin
            cls = CL_OTHER;
        end
    end

    assign eff_limit = (i_line_limit > MaxFill) ? MaxFill : i_line_limit;
    assign fill_m1   = r_fill - 4'd1;
    assign fill_m2   = r_fill - 4'd2;
    assign out_free  = !r_out_valid || i_out_ready;
    assign step_end  = (r_step == 2'd2);

    // single read port: list walk, top of line, or the one below it
    always_comb begin
        if (i_cmd.src == SRC_LIST) begin
            rd_sel = r_idx;
        end else if (step_end) begin
            rd_sel = fill_m2;
        end else begin
            rd_sel = fill_m1;
        end
    end
    assign rd_idx  = rd_sel[IdxW-1:0];
    assign wr_idx  = r_fill[IdxW-1:0];
    assign rd_char = r_store[rd_idx];

    always_comb begin
        o_stat.cls        = cls;
        o_stat.fill_zero  = (r_fill == '0);
        o_stat.room       = (r_fill < eff_limit);
        o_stat.out_free   = out_free;
        o_stat.step_end   = step_end;
        o_stat.idx_end    = (r_idx == fill_m1);
        // after this erase: more to go?
        o_stat.erase_more = (fill_m1 != '0) &&
                            ((cls == CL_KILL) ||
                             ((cls == CL_WERASE) &&
                              !(r_word && ({1'b0, rd_char} == CH_SP))));
    end

    // result word for the current source
    always_comb begin
        res_kind = KIND_ECHO;
        res_byte = '0;
        res_len  = '0;
        case (i_cmd.src)
            SRC_CHAR: begin
                res_byte = r_char;
            end
            SRC_BELL: begin
                res_kind = KIND_BELL;
            end
            SRC_PREFIX: begin
                case (r_step)
                    2'd0:    res_byte = CH_CARET;
                    2'd1:    res_byte = (cls == CL_INTR) ? CH_UC_C : CH_UC_R;
                    default: res_byte = CH_LF;
                endcase
            end
            SRC_LIST: begin
                res_kind = (cls == CL_ENTER) ? KIND_BYTE : KIND_ECHO;
                res_byte = {1'b0, rd_char};
            end
            SRC_DONE: begin
                res_kind = KIND_DONE;
                res_len  = (cls == CL_ENTER) ? r_fill : '0;
            end
            SRC_ERASE: begin
                res_byte = (r_step == 2'd1) ? CH_SP : CH_BS;
            end
            default: begin
                res_kind = KIND_ECHO;
            end
        endcase
    end

    always_comb begin
        n_fill = r_fill;
        if (i_cmd.emit) begin
            case (i_cmd.src)
                SRC_CHAR:  n_fill = r_fill + 4'd1;
                SRC_DONE:  n_fill = '0;
                SRC_ERASE: n_fill = step_end ? fill_m1 : r_fill;
                default:   n_fill = r_fill;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_fill <= n_fill;
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_char <= i_typed_byte;
            r_idx  <= '0;
            r_word <= 1'b0;
            r_step <= (i_typed_byte == CH_LF || i_typed_byte == CH_CR) ? 2'd2 : 2'd0;
        end else if (i_cmd.emit) begin
            case (i_cmd.src)
                SRC_PREFIX: begin
                    r_step <= r_step + 2'd1;
                end
                SRC_LIST: begin
                    r_idx <= r_idx + 4'd1;
                end
                SRC_ERASE: begin
                    r_step <= step_end ? 2'd0 : r_step + 2'd1;
                    if (r_step == 2'd0 && {1'b0, rd_char} != CH_SP) begin
                        r_word <= 1'b1;
                    end
                end
                default: begin
                    r_step <= r_step;
                end
            endcase
        end
        if (i_cmd.emit && i_cmd.src == SRC_CHAR) begin
            r_store[wr_idx] <= r_char[CharW-1:0];
        end
        if (i_cmd.emit) begin
            r_out_kind <= res_kind;
            r_out_byte <= res_byte;
            r_out_len  <= res_len;
            r_out_last <= i_cmd.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_kind  = r_out_kind;
    assign o_out_byte  = r_out_byte;
    assign o_out_len   = r_out_len;
    assign o_out_last  = r_out_last;

endmodule
`default_nettype wire

FILE: rtl/core/cle_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Console line editor controller
// Decodes the held word and steps through the result sequence.
// ----------------------------------------------------------------------------
module cle_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  wire cle_pkg::t_stat i_stat,
    output cle_pkg::t_cmd       o_cmd
);
    import cle_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECODE = 3'd1;
    localparam logic [2:0] ST_CHAR   = 3'd2;
    localparam logic [2:0] ST_BELL   = 3'd3;
    localparam logic [2:0] ST_PREFIX = 3'd4;
    localparam logic [2:0] ST_LIST   = 3'd5;
    localparam logic [2:0] ST_DONE   = 3'd6;
    localparam logic [2:0] ST_ERASE  = 3'd7;

    logic [2:0] r_state, n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
                if (i_in_valid) begin
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                case (i_stat.cls)
                    CL_ENTER, CL_INTR, CL_REPRINT: n_state = ST_PREFIX;
                    CL_PRINT:  n_state = i_stat.room ? ST_CHAR : ST_BELL;
                    CL_BKSP:   n_state = i_stat.fill_zero ? ST_BELL : ST_ERASE;
                    CL_KILL, CL_WERASE: n_state = i_stat.fill_zero ? ST_IDLE : ST_ERASE;
                    default:   n_state = ST_BELL;
                endcase
            end
            ST_CHAR, ST_BELL, ST_DONE: begin
                o_cmd.src  = (r_state == ST_CHAR) ? SRC_CHAR :
                             (r_state == ST_BELL) ? SRC_BELL : SRC_DONE;
                o_cmd.last = 1'b1;
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            ST_PREFIX: begin
                o_cmd.src  = SRC_PREFIX;
                o_cmd.last = i_stat.step_end && (i_stat.cls == CL_REPRINT) &&
                             i_stat.fill_zero;
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.step_end) begin
                        if (i_stat.cls == CL_INTR) begin
                            n_state = ST_DONE;
                        end else if (!i_stat.fill_zero) begin
                            n_state = ST_LIST;
                        end else if (i_stat.cls == CL_ENTER) begin
                            n_state = ST_DONE;
                        end else begin
                            n_state = ST_IDLE;
                        end
                    end
                end
            end
            ST_LIST: begin
                o_cmd.src  = SRC_LIST;
                o_cmd.last = i_stat.idx_end && (i_stat.cls == CL_REPRINT);
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.idx_end) begin
                        n_state = (i_stat.cls == CL_ENTER) ? ST_DONE : ST_IDLE;
                    end
                end
            end
            ST_ERASE: begin
                o_cmd.src  = SRC_ERASE;
                o_cmd.last = i_stat.step_end && !i_stat.erase_more;
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.step_end && !i_stat.erase_more) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/console_line_editor.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Console line editor
// Canonical terminal line discipline: line buffer, editing keys, echo and
// line delivery, with an APB register for the line limit.
// ----------------------------------------------------------------------------
// One typed word is taken at a time, only while the controller is idle. A
// word is held in a register and decoded in the DECODE state, then produces
// one result word per cycle into a single output register, which the sink
// may stall at will. An item gives 0 to 45 result words (ctrl-U on a full
// 15-character line gives 45), and the next word is taken in the cycle
// after the last result is loaded. The rate is set by the single result
// register and the one-port line store walked by the controller. No
// clearing pass is needed after reset: the store is only read below the
// fill count.
// ----------------------------------------------------------------------------
module console_line_editor #(
    parameter int LINE_DEPTH = 16
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    cle_in_if.sink                            i_in,
    cle_out_if.source                         o_out,
    // APB register port
    input  wire                               psel,
    input  wire                               penable,
    input  wire                               pwrite,
    input  wire  [cle_pkg::ApbAddrW-1:0]      paddr,
    input  wire  [cle_pkg::ApbDataW-1:0]      pwdata,
    output logic [cle_pkg::ApbDataW-1:0]      prdata,
    output logic                              pready
);
    import cle_pkg::*;

    logic [LimitW-1:0] r_limit;
    logic              reg_sel;
    t_cmd              cmd;
    t_stat             stat;

    // Register decode: word index from paddr[2]; anything else reads zero.
    assign reg_sel = (paddr[2] == REG_LINE_LIMIT);
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? ApbDataW'(r_limit) : '0;

    // line_limit is written on the access phase of a write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            r_limit <= pwdata[LimitW-1:0];
        end
    end

    // Controller: decode and sequence of result words
    cle_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Datapath: line store, counters and the output register
    cle_datapath #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_typed_byte (i_in.typed_byte),
        .i_line_limit (r_limit),
        .o_out_valid  (o_out.valid),
        .i_out_ready  (o_out.ready),
        .o_out_kind   (o_out.kind),
        .o_out_byte   (o_out.out_byte),
        .o_out_len    (o_out.line_length),
        .o_out_last   (o_out.last)
    );

endmodule
`default_nettype wire
